@@ rtl/pair_relative_momentum_unit_macros.svh @@
// Assertion macros for the pair relative momentum unit.
`ifndef PAIR_RELATIVE_MOMENTUM_UNIT_MACROS_SVH
`define PAIR_RELATIVE_MOMENTUM_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define PRMU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pair relative momentum unit: check failed");
`define PRMU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pair relative momentum unit: check failed");
`else
`define PRMU_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PRMU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/prmu_pkg.sv @@
package prmu_pkg;

  localparam int CB = 24;
  localparam int SW = CB + 1;
  localparam int PW = 2 * SW;
  localparam int AW = PW + 2;
  localparam int RW = AW / 2;
  localparam int QW = 32;
  localparam int MW = 31;
  localparam int FW = 3;
  localparam int NV = 4 + RW + 1 + QW;

  localparam int FLAG_MASS = 0;
  localparam int FLAG_PT   = 1;
  localparam int FLAG_LONG = 2;

  typedef struct packed {
    logic [RW:0]   rem;
    logic [RW-1:0] root;
    logic [AW-1:0] rad;
  } sq_t;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [QW-1:0] q;
    logic [QW-1:0] num;
    logic [RW-1:0] d;
  } dv_t;

  typedef struct packed {
    logic [FW-1:0] flags;
    logic          tneg;
    logic [AW-1:0] mag_out;
    logic [AW-1:0] mag_side;
    logic [AW-1:0] mag_long;
    logic          neg_out;
    logic          neg_side;
    logic          neg_long;
  } sq_side_t;

  typedef struct packed {
    logic [MW-1:0] mass;
    logic [QW-1:0] qinv;
    logic [FW-1:0] flags;
    logic          neg_out;
    logic          neg_side;
    logic          neg_long;
    logic          ovf_out;
    logic          ovf_side;
    logic          ovf_long;
  } dv_side_t;

  function automatic sq_t sq_step(sq_t a);
    logic [RW+2:0] cur;
    logic [RW+2:0] trial;
    sq_t r;
    cur   = {a.rem, a.rad[AW-1 -: 2]};
    trial = {1'b0, a.root, 2'b01};
    r.rad = a.rad << 2;
    if (cur >= trial) begin
      r.rem  = (RW+1)'(cur - trial);
      r.root = {a.root[RW-2:0], 1'b1};
    end else begin
      r.rem  = (RW+1)'(cur);
      r.root = {a.root[RW-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic dv_t dv_step(dv_t a);
    logic [RW:0] cur;
    dv_t r;
    cur   = {a.rem, a.num[QW-1]};
    r.d   = a.d;
    r.num = a.num << 1;
    if (cur >= {1'b0, a.d}) begin
      r.rem = RW'(cur - {1'b0, a.d});
      r.q   = {a.q[QW-2:0], 1'b1};
    end else begin
      r.rem = RW'(cur);
      r.q   = {a.q[QW-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [QW-1:0] sat_q(logic neg, logic ovf, logic [QW-1:0] q);
    logic [QW-1:0] lim;
    logic [QW-1:0] res;
    lim = {1'b1, {(QW-1){1'b0}}};
    if (neg) begin
      res = (ovf || q > lim) ? lim : (~q + 1'b1);
    end else begin
      res = (ovf || q[QW-1]) ? ~lim : q;
    end
    return res;
  endfunction

endpackage

@@ rtl/prmu_isqrt.sv @@
module prmu_isqrt (
  input  logic                      clk,
  input  logic                      en,
  input  logic [prmu_pkg::AW-1:0]   rad,
  output logic [prmu_pkg::RW-1:0]   root
);

  prmu_pkg::sq_t st_r [prmu_pkg::RW];

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= prmu_pkg::sq_step('{rem: '0, root: '0, rad: rad});
      for (int k = 1; k < prmu_pkg::RW; k++) begin
        st_r[k] <= prmu_pkg::sq_step(st_r[k-1]);
      end
    end
  end

  assign root = st_r[prmu_pkg::RW-1].root;

endmodule

@@ rtl/pair_relative_momentum_unit.sv @@
// Pair relative momentum unit.
// Input channel: in_valid / in_stall carry one particle pair per request, two
// four-momenta in signed fixed point with LSB 1/16 MeV.
// Output channel: out_valid / out_stall carry invariant mass, signed qinv,
// q_out, q_side, q_long and three status flags for each pair, in order.
// A request accepted at a clock edge passes through these registered stages
// before it reaches the output register: four arithmetic stages, 26 stages of
// the digit-by-digit square root, one setup stage and 32 stages of the
// restoring divider.
// Throughput: one pair per cycle while the output is not stalled; every stage is
// one square root or divider digit, one 25x25 multiply, or one wide add.
// Reset clears every valid bit of the pipeline and the output register; data
// registers are not reset.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall rises in the same cycle; bubbles are not squeezed out.
`include "pair_relative_momentum_unit_macros.svh"

module pair_relative_momentum_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [prmu_pkg::CB-1:0]   in_first_energy,
  input  logic signed [prmu_pkg::CB-1:0]   in_first_px,
  input  logic signed [prmu_pkg::CB-1:0]   in_first_py,
  input  logic signed [prmu_pkg::CB-1:0]   in_first_pz,
  input  logic signed [prmu_pkg::CB-1:0]   in_second_energy,
  input  logic signed [prmu_pkg::CB-1:0]   in_second_px,
  input  logic signed [prmu_pkg::CB-1:0]   in_second_py,
  input  logic signed [prmu_pkg::CB-1:0]   in_second_pz,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic        [prmu_pkg::MW-1:0]   out_invariant_mass,
  output logic signed [prmu_pkg::QW-1:0]   out_signed_qinv,
  output logic signed [prmu_pkg::QW-1:0]   out_q_out,
  output logic signed [prmu_pkg::QW-1:0]   out_q_side,
  output logic signed [prmu_pkg::QW-1:0]   out_q_long,
  output logic        [prmu_pkg::FW-1:0]   out_status_flags
);

  localparam int SW = prmu_pkg::SW;
  localparam int PW = prmu_pkg::PW;
  localparam int AW = prmu_pkg::AW;
  localparam int RW = prmu_pkg::RW;
  localparam int QW = prmu_pkg::QW;
  localparam int NV = prmu_pkg::NV;

  logic en;
  logic [NV-1:0] vpipe_r;
  logic out_valid_r;

  logic signed [SW-1:0] e_r, px_r, py_r, pz_r, q0_r, qx_r, qy_r, qz_r;
  logic signed [PW-1:0] ee_r, xx_r, yy_r, zz_r, q00_r, qxx_r, qyy_r, qzz_r;
  logic signed [PW-1:0] o1_r, o2_r, s1_r, s2_r, l1_r, l2_r;
  logic signed [AW-1:0] m2_r, t_r, s_r, d2_r, no_r, ns_r, nl_r;

  logic [AW-1:0] rad_m_r, rad_t_r, rad_s_r, rad_d_r;
  prmu_pkg::sq_side_t sd4_nxt, sd4_r;
  prmu_pkg::sq_side_t sd_r [RW];
  logic [RW-1:0] root_m, root_t, root_s, root_d;

  prmu_pkg::dv_side_t ds5_nxt, ds5_r;
  prmu_pkg::dv_t i_out_nxt, i_side_nxt, i_long_nxt;
  prmu_pkg::dv_t i_out_r, i_side_r, i_long_r;
  prmu_pkg::dv_t do_r [QW];
  prmu_pkg::dv_t dsd_r [QW];
  prmu_pkg::dv_t dl_r [QW];
  prmu_pkg::dv_side_t dd_r [QW];
  prmu_pkg::dv_side_t dfin;

  logic [RW-1:0] pt, dl;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vpipe_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vpipe_r     <= {vpipe_r[NV-2:0], in_valid};
      out_valid_r <= vpipe_r[NV-1];
    end
  end

  // sums, differences and products
  always_ff @(posedge clk) begin
    if (en) begin
      e_r  <= SW'(in_first_energy) + SW'(in_second_energy);
      px_r <= SW'(in_first_px) + SW'(in_second_px);
      py_r <= SW'(in_first_py) + SW'(in_second_py);
      pz_r <= SW'(in_first_pz) + SW'(in_second_pz);
      q0_r <= SW'(in_first_energy) - SW'(in_second_energy);
      qx_r <= SW'(in_first_px) - SW'(in_second_px);
      qy_r <= SW'(in_first_py) - SW'(in_second_py);
      qz_r <= SW'(in_first_pz) - SW'(in_second_pz);

      ee_r  <= PW'(e_r) * PW'(e_r);
      xx_r  <= PW'(px_r) * PW'(px_r);
      yy_r  <= PW'(py_r) * PW'(py_r);
      zz_r  <= PW'(pz_r) * PW'(pz_r);
      q00_r <= PW'(q0_r) * PW'(q0_r);
      qxx_r <= PW'(qx_r) * PW'(qx_r);
      qyy_r <= PW'(qy_r) * PW'(qy_r);
      qzz_r <= PW'(qz_r) * PW'(qz_r);
      o1_r  <= PW'(qx_r) * PW'(px_r);
      o2_r  <= PW'(qy_r) * PW'(py_r);
      s1_r  <= PW'(qy_r) * PW'(px_r);
      s2_r  <= PW'(qx_r) * PW'(py_r);
      l1_r  <= PW'(qz_r) * PW'(e_r);
      l2_r  <= PW'(pz_r) * PW'(q0_r);

      m2_r <= AW'(ee_r) - AW'(xx_r) - AW'(yy_r) - AW'(zz_r);
      t_r  <= AW'(q00_r) - AW'(qxx_r) - AW'(qyy_r) - AW'(qzz_r);
      s_r  <= AW'(xx_r) + AW'(yy_r);
      d2_r <= AW'(ee_r) - AW'(zz_r);
      no_r <= AW'(o1_r) + AW'(o2_r);
      ns_r <= AW'(s1_r) - AW'(s2_r);
      nl_r <= AW'(l1_r) - AW'(l2_r);
    end
  end

  always_comb begin
    sd4_nxt = '0;
    sd4_nxt.flags[prmu_pkg::FLAG_MASS] = m2_r[AW-1];
    sd4_nxt.flags[prmu_pkg::FLAG_PT]   = (s_r == '0);
    sd4_nxt.flags[prmu_pkg::FLAG_LONG] = d2_r[AW-1] || (d2_r == '0);
    sd4_nxt.tneg     = t_r[AW-1] || (t_r == '0);
    sd4_nxt.neg_out  = no_r[AW-1];
    sd4_nxt.neg_side = ns_r[AW-1];
    sd4_nxt.neg_long = nl_r[AW-1];
    sd4_nxt.mag_out  = no_r[AW-1] ? $unsigned(-no_r) : $unsigned(no_r);
    sd4_nxt.mag_side = ns_r[AW-1] ? $unsigned(-ns_r) : $unsigned(ns_r);
    sd4_nxt.mag_long = nl_r[AW-1] ? $unsigned(-nl_r) : $unsigned(nl_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_m_r <= m2_r[AW-1] ? '0 : $unsigned(m2_r);
      rad_t_r <= t_r[AW-1] ? $unsigned(-t_r) : $unsigned(t_r);
      rad_s_r <= $unsigned(s_r);
      rad_d_r <= sd4_nxt.flags[prmu_pkg::FLAG_LONG] ? '0 : $unsigned(d2_r);
      sd4_r   <= sd4_nxt;
    end
  end

  prmu_isqrt u_sqrt_m (.clk(clk), .en(en), .rad(rad_m_r), .root(root_m));
  prmu_isqrt u_sqrt_t (.clk(clk), .en(en), .rad(rad_t_r), .root(root_t));
  prmu_isqrt u_sqrt_s (.clk(clk), .en(en), .rad(rad_s_r), .root(root_s));
  prmu_isqrt u_sqrt_d (.clk(clk), .en(en), .rad(rad_d_r), .root(root_d));

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= sd4_r;
      for (int k = 1; k < RW; k++) begin
        sd_r[k] <= sd_r[k-1];
      end
    end
  end

  // divider setup: pick divisors and flag quotients that cannot fit
  always_comb begin
    pt = sd_r[RW-1].flags[prmu_pkg::FLAG_PT] ? RW'(1) : root_s;
    dl = sd_r[RW-1].flags[prmu_pkg::FLAG_LONG] ? RW'(1) : root_d;

    ds5_nxt.mass     = prmu_pkg::MW'(root_m);
    ds5_nxt.qinv     = sd_r[RW-1].tneg ? (~QW'(root_t) + 1'b1) : QW'(root_t);
    ds5_nxt.flags    = sd_r[RW-1].flags;
    ds5_nxt.neg_out  = sd_r[RW-1].neg_out;
    ds5_nxt.neg_side = sd_r[RW-1].neg_side;
    ds5_nxt.neg_long = sd_r[RW-1].neg_long;
    ds5_nxt.ovf_out  = RW'(sd_r[RW-1].mag_out[AW-1:QW]) >= pt;
    ds5_nxt.ovf_side = RW'(sd_r[RW-1].mag_side[AW-1:QW]) >= pt;
    ds5_nxt.ovf_long = RW'(sd_r[RW-1].mag_long[AW-1:QW]) >= dl;

    i_out_nxt.rem  = RW'(sd_r[RW-1].mag_out[AW-1:QW]);
    i_out_nxt.q    = '0;
    i_out_nxt.num  = sd_r[RW-1].mag_out[QW-1:0];
    i_out_nxt.d    = pt;
    i_side_nxt.rem = RW'(sd_r[RW-1].mag_side[AW-1:QW]);
    i_side_nxt.q   = '0;
    i_side_nxt.num = sd_r[RW-1].mag_side[QW-1:0];
    i_side_nxt.d   = pt;
    i_long_nxt.rem = RW'(sd_r[RW-1].mag_long[AW-1:QW]);
    i_long_nxt.q   = '0;
    i_long_nxt.num = sd_r[RW-1].mag_long[QW-1:0];
    i_long_nxt.d   = dl;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ds5_r    <= ds5_nxt;
      i_out_r  <= i_out_nxt;
      i_side_r <= i_side_nxt;
      i_long_r <= i_long_nxt;

      do_r[0]  <= prmu_pkg::dv_step(i_out_r);
      dsd_r[0] <= prmu_pkg::dv_step(i_side_r);
      dl_r[0]  <= prmu_pkg::dv_step(i_long_r);
      dd_r[0]  <= ds5_r;
      for (int k = 1; k < QW; k++) begin
        do_r[k]  <= prmu_pkg::dv_step(do_r[k-1]);
        dsd_r[k] <= prmu_pkg::dv_step(dsd_r[k-1]);
        dl_r[k]  <= prmu_pkg::dv_step(dl_r[k-1]);
        dd_r[k]  <= dd_r[k-1];
      end
    end
  end

  assign dfin = dd_r[QW-1];

  always_ff @(posedge clk) begin
    if (en) begin
      out_invariant_mass <= dfin.mass;
      out_signed_qinv    <= dfin.qinv;
      out_status_flags   <= dfin.flags;
      out_q_out  <= dfin.flags[prmu_pkg::FLAG_PT] ? '0 :
                    prmu_pkg::sat_q(dfin.neg_out, dfin.ovf_out, do_r[QW-1].q);
      out_q_side <= dfin.flags[prmu_pkg::FLAG_PT] ? '0 :
                    prmu_pkg::sat_q(dfin.neg_side, dfin.ovf_side, dsd_r[QW-1].q);
      out_q_long <= dfin.flags[prmu_pkg::FLAG_LONG] ? '0 :
                    prmu_pkg::sat_q(dfin.neg_long, dfin.ovf_long, dl_r[QW-1].q);
    end
  end

  `PRMU_ASSERT_IMPL(a_mass_zero, clk, rst_n, out_valid_r && out_status_flags[prmu_pkg::FLAG_MASS], out_invariant_mass == '0)
  `PRMU_ASSERT_IMPL(a_pt_zero, clk, rst_n, out_valid_r && out_status_flags[prmu_pkg::FLAG_PT], out_q_out == '0 && out_q_side == '0)
  `PRMU_ASSERT_IMPL(a_long_zero, clk, rst_n, out_valid_r && out_status_flags[prmu_pkg::FLAG_LONG], out_q_long == '0)
  `PRMU_ASSERT_NEXT(a_pipe_hold, clk, rst_n, out_valid_r && out_stall, $stable(vpipe_r))
  `PRMU_ASSERT_NEXT(a_drain, clk, rst_n, en && vpipe_r[NV-1], out_valid_r)

endmodule
